>>> sv/segment_intersection_top_assert.svh
// assertion macros for the segment intersection pipeline
// expects clk and rst in the scope of each use
`ifndef SEGMENT_INTERSECTION_TOP_ASSERT_SVH
`define SEGMENT_INTERSECTION_TOP_ASSERT_SVH

// same-cycle implication
`define SIT_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("segment intersection check failed");

// next-cycle implication
`define SIT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("segment intersection check failed");

`endif

>>> sv/segx_pkg.sv
// shared types for the segment intersection pipeline
// no dependencies
package segx_pkg;

  typedef struct packed {
    logic valid;
    logic hit;
  } ctl_t;

  localparam int AVG_SHIFT = 2;

endpackage

>>> sv/segx_div.sv
// pipelined restoring divider, one quotient bit per stage, sideband carried along
// depends on segx_pkg and segment_intersection_top_assert.svh
`include "segment_intersection_top_assert.svh"

module segx_div #(
  parameter int RW     = 53,
  parameter int F      = 32,
  parameter int SIDE_W = 124
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  segx_pkg::ctl_t       in_ctl,
  input  logic [RW-1:0]        in_rem,
  input  logic [RW-1:0]        in_den,
  input  logic [SIDE_W-1:0]    in_side,
  output segx_pkg::ctl_t       out_ctl,
  output logic [F-1:0]         out_quo,
  output logic [SIDE_W-1:0]    out_side
);

  segx_pkg::ctl_t    ctl_q  [1:F];
  logic [RW-1:0]     rem_q  [1:F];
  logic [RW-1:0]     den_q  [1:F];
  logic [F-1:0]      quo_q  [1:F];
  logic [SIDE_W-1:0] side_q [1:F];

  for (genvar k = 0; k < F; k++) begin : g_step
    segx_pkg::ctl_t    ctl_src;
    logic [RW-1:0]     rem_src;
    logic [RW-1:0]     den_src;
    logic [F-1:0]      quo_src;
    logic [SIDE_W-1:0] side_src;
    logic [RW:0]       r2;
    logic [RW:0]       diff;
    logic              take;

    if (k == 0) begin : g_first
      assign ctl_src  = in_ctl;
      assign rem_src  = in_rem;
      assign den_src  = in_den;
      assign quo_src  = '0;
      assign side_src = in_side;
    end else begin : g_rest
      assign ctl_src  = ctl_q[k];
      assign rem_src  = rem_q[k];
      assign den_src  = den_q[k];
      assign quo_src  = quo_q[k];
      assign side_src = side_q[k];
    end

    assign r2   = {rem_src, 1'b0};
    assign diff = r2 - {1'b0, den_src};
    assign take = r2 >= {1'b0, den_src};

    always_ff @(posedge clk) begin
      if (rst) begin
        ctl_q[k+1] <= '0;
      end else if (en) begin
        ctl_q[k+1] <= ctl_src;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k+1]  <= take ? diff[RW-1:0] : r2[RW-1:0];
        den_q[k+1]  <= den_src;
        quo_q[k+1]  <= {quo_src[F-2:0], take};
        side_q[k+1] <= side_src;
      end
    end
  end

  assign out_ctl  = ctl_q[F];
  assign out_quo  = quo_q[F];
  assign out_side = side_q[F];

  `SIT_ASSERT_IMPL(a_rem_below_den, ctl_q[F].valid && ctl_q[F].hit, rem_q[F] < den_q[F])
  `SIT_ASSERT_NEXT(a_stall_holds_quo, !en, $stable(quo_q[F]) && $stable(ctl_q[F]))

endmodule

>>> sv/segment_intersection_top.sv
// segment intersection top level: line-equation front end, divider, scaling back end
// depends on segx_pkg, segx_div and segment_intersection_top_assert.svh
//
//   port group   dir  payload, lowest bit first
//   s_axis       in   a_start_x/y/z, a_end_x/y/z, b_start_x/y/z, b_end_x/y/z
//   m_axis       out  hit, cross_x, cross_y, cross_z
//
// one transfer per cycle in each direction while the pipeline is not held
// the divider computes one quotient bit per stage
// rst clears all valid bits; payload registers are left as they are
// the whole pipeline holds while a result waits on m_axis_tready
`include "segment_intersection_top_assert.svh"

module segment_intersection_top #(
  parameter int COORD_BITS    = 24,
  parameter int FRACTION_BITS = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // seg_a_start_x, seg_a_start_y, seg_a_start_z, seg_a_end_x, seg_a_end_y, seg_a_end_z,
  // seg_b_start_x, seg_b_start_y, seg_b_start_z, seg_b_end_x, seg_b_end_y, seg_b_end_z
  input  logic [((12*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // hit, cross_x, cross_y, cross_z
  output logic [((3*COORD_BITS+1+7)/8)*8-1:0] m_axis_tdata
);

  localparam int C      = COORD_BITS;
  localparam int F      = FRACTION_BITS;
  localparam int DW     = C + 1;
  localparam int PW     = 2 * DW;
  localparam int SW     = PW + 1;
  localparam int RW     = SW + 1;
  localparam int FL     = F / 2;
  localparam int FH     = F - FL;
  localparam int O_AY   = C;
  localparam int O_MX   = 2 * C;
  localparam int O_MY   = 2 * C + DW;
  localparam int O_SX   = 2 * C + 2 * DW;
  localparam int O_SY   = O_SX + 1;
  localparam int O_Z    = O_SX + 2;
  localparam int SIDE_W = 3 * C + 2 * DW + 2;

  logic en;
  logic signed [C-1:0] in_f [0:11];

  // stage 1: differences and partial height sums
  segx_pkg::ctl_t c1;
  logic signed [DW-1:0] d1x, d1y, d2x, d2y;
  logic signed [DW-1:0] acx, acy, bcx, bcy, cax, cay, eax, eay;
  logic signed [C-1:0]  ax1, ay1;
  logic signed [C:0]    zab, zce;

  // stage 2: cross products
  segx_pkg::ctl_t c2;
  logic signed [PW-1:0] pr [0:7];
  logic [SIDE_W-1:0]    side2;
  logic signed [C+1:0]  zsum;
  logic [DW-1:0]        magx_n, magy_n;

  // stage 3: side values
  segx_pkg::ctl_t c3;
  logic signed [SW-1:0] s3, e3, t3, f3;
  logic [SIDE_W-1:0]    side3;

  // stage 4: sign test and magnitudes
  segx_pkg::ctl_t c4;
  logic [SW-1:0]     mag_s, mag_e;
  logic [SIDE_W-1:0] side4;

  // stage 5: divider operands
  segx_pkg::ctl_t c5;
  logic [RW-1:0]     rem5, den5;
  logic [SIDE_W-1:0] side5;

  // divider output
  segx_pkg::ctl_t    cd;
  logic [F-1:0]      quo;
  logic [SIDE_W-1:0] sided;

  // scaling stages
  segx_pkg::ctl_t     cm1, cm2, co;
  logic [FL+DW-1:0]   plx, ply;
  logic [FH+DW-1:0]   phx, phy;
  logic [SIDE_W-1:0]  side_m1, side_m2;
  logic [F+DW-1:0]    px, py;
  logic [DW-1:0]      qx, qy;
  logic               lx, ly;
  logic signed [DW:0] rx_n, ry_n;
  logic               o_hit;
  logic [C-1:0]       o_x, o_y, o_z;

  assign en            = !co.valid || m_axis_tready;
  assign s_axis_tready = en;

  for (genvar i = 0; i < 12; i++) begin : g_field
    assign in_f[i] = s_axis_tdata[i*C +: C];
  end

  // control path
  always_ff @(posedge clk) begin
    if (rst) begin
      c1  <= '0;
      c2  <= '0;
      c3  <= '0;
      c4  <= '0;
      c5  <= '0;
      cm1 <= '0;
      cm2 <= '0;
      co  <= '0;
    end else if (en) begin
      c1.valid <= s_axis_tvalid;
      c1.hit   <= 1'b0;
      c2       <= c1;
      c3       <= c2;
      c4.valid <= c3.valid;
      c4.hit   <= !(s3 == '0 || e3 == '0 || s3[SW-1] == e3[SW-1]) &&
                  !(t3 == '0 || f3 == '0 || t3[SW-1] == f3[SW-1]);
      c5       <= c4;
      cm1      <= cd;
      cm2      <= cm1;
      co       <= cm2;
    end
  end

  // front end payload
  always_comb begin
    zsum   = (C+2)'(zab) + (C+2)'(zce);
    magx_n = d1x[DW-1] ? DW'(-d1x) : DW'(d1x);
    magy_n = d1y[DW-1] ? DW'(-d1y) : DW'(d1y);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax1 <= in_f[0];
      ay1 <= in_f[1];
      d1x <= DW'(in_f[3]) - DW'(in_f[0]);
      d1y <= DW'(in_f[4]) - DW'(in_f[1]);
      d2x <= DW'(in_f[9]) - DW'(in_f[6]);
      d2y <= DW'(in_f[10]) - DW'(in_f[7]);
      acx <= DW'(in_f[0]) - DW'(in_f[6]);
      acy <= DW'(in_f[1]) - DW'(in_f[7]);
      bcx <= DW'(in_f[3]) - DW'(in_f[6]);
      bcy <= DW'(in_f[4]) - DW'(in_f[7]);
      cax <= DW'(in_f[6]) - DW'(in_f[0]);
      cay <= DW'(in_f[7]) - DW'(in_f[1]);
      eax <= DW'(in_f[9]) - DW'(in_f[0]);
      eay <= DW'(in_f[10]) - DW'(in_f[1]);
      zab <= (C+1)'(in_f[2]) + (C+1)'(in_f[5]);
      zce <= (C+1)'(in_f[8]) + (C+1)'(in_f[11]);

      pr[0] <= d2x * acy;
      pr[1] <= d2y * acx;
      pr[2] <= d2x * bcy;
      pr[3] <= d2y * bcx;
      pr[4] <= d1x * cay;
      pr[5] <= d1y * cax;
      pr[6] <= d1x * eay;
      pr[7] <= d1y * eax;
      side2 <= {zsum[C+1:segx_pkg::AVG_SHIFT], d1y[DW-1], d1x[DW-1], magy_n, magx_n,
                ay1, ax1};

      s3    <= SW'(pr[0]) - SW'(pr[1]);
      e3    <= SW'(pr[2]) - SW'(pr[3]);
      t3    <= SW'(pr[4]) - SW'(pr[5]);
      f3    <= SW'(pr[6]) - SW'(pr[7]);
      side3 <= side2;

      mag_s <= s3[SW-1] ? SW'(-s3) : SW'(s3);
      mag_e <= e3[SW-1] ? SW'(-e3) : SW'(e3);
      side4 <= side3;

      rem5  <= RW'(mag_s);
      den5  <= RW'(mag_s) + RW'(mag_e);
      side5 <= side4;
    end
  end

  segx_div #(
    .RW     (RW),
    .F      (F),
    .SIDE_W (SIDE_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_ctl   (c5),
    .in_rem   (rem5),
    .in_den   (den5),
    .in_side  (side5),
    .out_ctl  (cd),
    .out_quo  (quo),
    .out_side (sided)
  );

  // back end: u times direction, floored, added to the first start point
  always_comb begin
    px = {phx, {FL{1'b0}}} + (F+DW)'(plx);
    py = {phy, {FL{1'b0}}} + (F+DW)'(ply);
    if (side_m2[O_SX]) begin
      rx_n = (DW+1)'($signed(side_m2[C-1:0])) + (DW+1)'(~{1'b0, qx}) + (DW+1)'(!lx);
    end else begin
      rx_n = (DW+1)'($signed(side_m2[C-1:0])) + (DW+1)'({1'b0, qx});
    end
    if (side_m2[O_SY]) begin
      ry_n = (DW+1)'($signed(side_m2[O_AY +: C])) + (DW+1)'(~{1'b0, qy}) + (DW+1)'(!ly);
    end else begin
      ry_n = (DW+1)'($signed(side_m2[O_AY +: C])) + (DW+1)'({1'b0, qy});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      plx     <= quo[FL-1:0] * sided[O_MX +: DW];
      phx     <= quo[F-1:FL] * sided[O_MX +: DW];
      ply     <= quo[FL-1:0] * sided[O_MY +: DW];
      phy     <= quo[F-1:FL] * sided[O_MY +: DW];
      side_m1 <= sided;

      qx      <= px[F+DW-1:F];
      qy      <= py[F+DW-1:F];
      lx      <= |px[F-1:0];
      ly      <= |py[F-1:0];
      side_m2 <= side_m1;

      o_hit <= cm2.hit;
      o_x   <= cm2.hit ? rx_n[C-1:0] : '0;
      o_y   <= cm2.hit ? ry_n[C-1:0] : '0;
      o_z   <= cm2.hit ? side_m2[O_Z +: C] : '0;
    end
  end

  assign m_axis_tvalid = co.valid;

  always_comb begin
    m_axis_tdata         = '0;
    m_axis_tdata[3*C:0]  = {o_z, o_y, o_x, o_hit};
  end

  `SIT_ASSERT_IMPL(a_nohit_zero, co.valid && !o_hit, o_x == '0 && o_y == '0 && o_z == '0)
  `SIT_ASSERT_IMPL(a_hit_operands, c5.valid && c5.hit, rem5 != '0 && rem5 < den5)

endmodule
